// ===== design/csm_pkg.sv =====
// Shared types and constants for the CSR sparse matrix-vector multiplier.
`default_nettype none

package csm_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(VECTOR_DEPTH);
    localparam int VLEN_W       = 11;
    localparam int INDEX_W      = 10;
    localparam int ROW_W        = 16;

    localparam logic [VLEN_W-1:0] VLEN_RESET = VLEN_W'(1024);

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_NONZERO = 2'd1,
        MODE_EMPTY   = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode               mode;
        logic [INDEX_W-1:0]  index;
        logic signed [31:0]  value;
        logic                row_last;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]    row_number;
        logic signed [63:0]  row_sum;
        logic                saturated;
        logic                bad_column;
    } t_out_item;

    typedef struct packed {
        logic wr_vec;
        logic rd_vec;
        logic set_bad;
        logic mul;
        logic acc;
        logic emit;
        logic emit_zero;
    } t_cmd;

    typedef struct packed {
        logic col_bad;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== design/csm_ctrl.sv =====
// Controller state machine that sequences one input word at a time.
`default_nettype none

module csm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire csm_pkg::t_mode  i_mode,
    input  wire logic            i_last,
    input  wire csm_pkg::t_status i_status,
    output csm_pkg::t_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ACC  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;
    logic   r_zero, n_zero;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        n_zero  = r_zero;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_last = i_last;
                    n_zero = (i_mode == csm_pkg::MODE_EMPTY);
                    case (i_mode)
                        csm_pkg::MODE_LOAD: begin
                            o_cmd.wr_vec = 1'b1;
                        end
                        csm_pkg::MODE_NONZERO: begin
                            if (i_status.col_bad) begin
                                // An out-of-range column marks the row and is not multiplied.
                                o_cmd.set_bad = 1'b1;
                                if (i_last) begin
                                    n_state = S_EMIT;
                                end
                            end else begin
                                o_cmd.rd_vec = 1'b1;
                                n_state      = S_MUL;
                            end
                        end
                        csm_pkg::MODE_EMPTY: begin
                            n_state = S_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_zero = r_zero;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_zero  <= n_zero;
        end
    end

endmodule

`default_nettype wire

// ===== design/csm_datapath.sv =====
// Datapath: vector store, multiplier, saturating accumulator and result register.
`default_nettype none

module csm_datapath (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire csm_pkg::t_in_item        i_in,
    input  wire logic                     i_cfg_valid,
    input  wire logic [csm_pkg::VLEN_W-1:0] i_cfg_data,
    input  wire csm_pkg::t_cmd            i_cmd,
    output csm_pkg::t_status              o_status,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output csm_pkg::t_out_item            o_out
);

    logic signed [31:0] r_mem [csm_pkg::VECTOR_DEPTH];

    logic [csm_pkg::VLEN_W-1:0] r_vlen;
    logic signed [31:0]         r_val;
    logic signed [31:0]         r_rdata;
    logic signed [63:0]         r_prod;
    logic signed [63:0]         r_acc;
    logic [csm_pkg::ROW_W-1:0]  r_row;
    logic                       r_sat;
    logic                       r_bad;
    logic                       r_out_valid;
    csm_pkg::t_out_item         r_out;

    logic [csm_pkg::ADDR_W-1:0] addr;
    logic                       in_depth;
    logic signed [63:0]         sum;
    logic                       ovf;
    logic signed [63:0]         sat_sum;

    assign addr     = csm_pkg::ADDR_W'(i_in.index);
    assign in_depth = (32'(i_in.index) < csm_pkg::VECTOR_DEPTH);

    assign o_status.col_bad  = !in_depth || ({1'b0, i_in.index} >= r_vlen);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Overflow only when both addends share a sign and the sum does not.
    assign sum     = r_acc + r_prod;
    assign ovf     = (r_acc[63] == r_prod[63]) && (sum[63] != r_acc[63]);
    assign sat_sum = !ovf ? sum
                   : (r_acc[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}});

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_vec && in_depth) begin
            r_mem[addr] <= i_in.value;
        end
        if (i_cmd.rd_vec) begin
            r_rdata <= r_mem[addr];
            r_val   <= i_in.value;
        end
        if (i_cmd.mul) begin
            r_prod <= r_val * r_rdata;
        end
        if (i_cmd.emit) begin
            r_out.row_number <= r_row;
            r_out.row_sum    <= i_cmd.emit_zero ? '0 : r_acc;
            r_out.saturated  <= !i_cmd.emit_zero && r_sat;
            r_out.bad_column <= !i_cmd.emit_zero && r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen      <= csm_pkg::VLEN_RESET;
            r_acc       <= '0;
            r_row       <= '0;
            r_sat       <= 1'b0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_vlen <= i_cfg_data;
            end
            if (i_cmd.emit) begin
                r_acc       <= '0;
                r_sat       <= 1'b0;
                r_bad       <= 1'b0;
                r_row       <= r_row + 1'b1;
                r_out_valid <= 1'b1;
            end else begin
                if (i_cmd.acc) begin
                    r_acc <= sat_sum;
                    if (ovf) begin
                        r_sat <= 1'b1;
                    end
                end
                if (i_cmd.set_bad) begin
                    r_bad <= 1'b1;
                end
                if (r_out_valid && i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken word");
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_acc == '0) && !r_sat && !r_bad)
        else $error("row state not cleared after emit");
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_row == $past(r_row) + 1'b1) && r_out_valid)
        else $error("row counter did not advance on emit");
`endif

endmodule

`default_nettype wire

// ===== design/csr_sparse_matvec.sv =====
// Top level of the CSR sparse matrix times dense vector block.
//
// Input words arrive on i_in_valid/o_in_ready with a t_in_item payload.
// Mode 0 loads one vector entry, mode 1 brings one nonzero (column, value),
// mode 2 closes an empty row. A nonzero with row_last set ends the row and
// produces one result word on o_out_valid/i_out_ready: row number, the Q32.32
// saturating sum and the sticky saturation and bad-column flags.
// The vector length register is written through i_cfg_valid/i_cfg_data,
// always ready. Write it only while the block is idle; the block does not check.
// Loads, unknown modes and bad-column nonzeros that do not end a row are
// handled in the idle state; an empty row or a row ending on a bad column
// goes on to the emit state. An in-range nonzero passes through the vector
// store read, the 32x32 multiply and the saturating add, each registered.
// A row end then adds the emit state, which loads the result register.
// The result register lets the next word be taken while a result waits. If
// the receiver stalls and a second result is due, the block holds in its
// emit state until the first is taken. Reset clears the accumulator, flags,
// row counter and sets the vector length to 1024; the vector store is not
// cleared, and entries must be loaded before they are used.
`default_nettype none

module csr_sparse_matvec (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire csm_pkg::t_in_item          i_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output csm_pkg::t_out_item              o_out,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [csm_pkg::VLEN_W-1:0] i_cfg_data
);

    csm_pkg::t_cmd    cmd;
    csm_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    csm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_in.mode),
        .i_last     (i_in.row_last),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    csm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the CSR sparse matrix-vector multiplier.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csm_pkg::*;

    // The package has no name for the unused mode code; such a word must be ignored.
    localparam t_mode MODE_IGNORED = t_mode'(2'b11);
    localparam int    WORDS_PER_PHASE = 36;
    localparam int    DRAIN_CYCLES = 8;

    // Tracks the expected row results. It mirrors the vector, the running sum,
    // the sticky flags and the row count, and holds the rows that are due.
    class row_sum_tracker;
        logic signed [31:0] x_mem [VECTOR_DEPTH];
        logic signed [63:0] acc;
        logic [ROW_W-1:0]   row_cnt;
        logic               sat_seen;
        logic               bad_seen;
        logic [VLEN_W-1:0]  vlen;
        t_out_item          rows_due [$];
        int                 errors;

        function new();
            acc      = '0;
            row_cnt  = '0;
            sat_seen = 1'b0;
            bad_seen = 1'b0;
            vlen     = VLEN_RESET;
            errors   = 0;
        endfunction

        function void set_length(logic [VLEN_W-1:0] v);
            vlen = v;
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        function void close_row(logic signed [63:0] sum, logic sat, logic bad);
            t_out_item r;
            r.row_number = row_cnt;
            r.row_sum    = sum;
            r.saturated  = sat;
            r.bad_column = bad;
            rows_due.push_back(r);
            row_cnt  = row_cnt + 1'b1;
            acc      = '0;
            sat_seen = 1'b0;
            bad_seen = 1'b0;
        endfunction

        function void take_input(t_in_item w);
            logic signed [63:0] a;
            logic signed [63:0] b;
            logic signed [63:0] prod;
            logic signed [63:0] s;
            case (w.mode)
                MODE_LOAD: x_mem[w.index] = w.value;
                MODE_NONZERO: begin
                    if (int'(w.index) >= int'(vlen) || int'(w.index) >= VECTOR_DEPTH) begin
                        bad_seen = 1'b1;
                    end else begin
                        a    = 64'(w.value);
                        b    = 64'(x_mem[w.index]);
                        prod = a * b;
                        s    = acc + prod;
                        // Clip when both operands share a sign the sum does not.
                        if (acc[63] == prod[63] && s[63] != acc[63]) begin
                            s        = acc[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                            sat_seen = 1'b1;
                        end
                        acc = s;
                    end
                    if (w.row_last)
                        close_row(acc, sat_seen, bad_seen);
                end
                MODE_EMPTY: close_row('0, 1'b0, 1'b0);
                default: ;
            endcase
        endfunction

        task flag_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_row(t_out_item got);
            t_out_item e;
            if (rows_due.size() == 0) begin
                flag_mismatch($sformatf("row %0d arrived with no row due", got.row_number));
            end else begin
                e = rows_due.pop_front();
                if (got.row_number !== e.row_number)
                    flag_mismatch($sformatf("row_number %0d, expected %0d",
                                            got.row_number, e.row_number));
                if (got.row_sum !== e.row_sum)
                    flag_mismatch($sformatf("row %0d row_sum %h, expected %h",
                                            e.row_number, got.row_sum, e.row_sum));
                if (got.saturated !== e.saturated)
                    flag_mismatch($sformatf("row %0d saturated %b, expected %b",
                                            e.row_number, got.saturated, e.saturated));
                if (got.bad_column !== e.bad_column)
                    flag_mismatch($sformatf("row %0d bad_column %b, expected %b",
                                            e.row_number, got.bad_column, e.bad_column));
            end
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [VLEN_W-1:0] i_cfg_data = '0;

    row_sum_tracker sb = new();

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int cur_len = 1024;
    int words_sent = 0;
    bit loaded [VECTOR_DEPTH];
    int loaded_q [$];

    csr_sparse_matvec i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Handshakes are sampled at the edge, before any driver update lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_length(i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.take_input(i_in);
            if (o_out_valid && i_out_ready)
                sb.check_row(o_out);
        end
    end

    function automatic void set_idling(int m);
        case (m)
            0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
            1: begin in_idle_pct = 66; out_stall_pct = 0;  end
            2: begin in_idle_pct = 0;  out_stall_pct = 66; end
            default: begin in_idle_pct = 13; out_stall_pct = 13; end
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic push_word(t_mode m, int idx, logic [31:0] v, logic last);
        t_in_item w;
        w.mode     = m;
        w.index    = idx[INDEX_W-1:0];
        w.value    = v;
        w.row_last = last;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (!o_in_ready);
        if (m == MODE_LOAD && !loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_q.push_back(idx);
        end
        if (m != MODE_IGNORED)
            words_sent++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        // Let the handshakes of this edge reach the scoreboard before counting.
        @(posedge i_clk);
        while (sb.pending() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(int v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v[VLEN_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_len = v;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int column_limit();
        if (cur_len > VECTOR_DEPTH)
            return VECTOR_DEPTH;
        return (cur_len < 1) ? 1 : cur_len;
    endfunction

    // In-range columns only ever point at entries that have been loaded.
    function automatic int good_column();
        int lim;
        int c;
        lim = column_limit();
        for (int k = 0; k < 16; k++) begin
            c = loaded_q[$urandom_range(loaded_q.size() - 1)];
            if (c < lim)
                return c;
        end
        return 0;
    endfunction

    task automatic random_load();
        int idx;
        idx = ($urandom_range(1) == 0) ? $urandom_range(column_limit() - 1)
                                       : $urandom_range(VECTOR_DEPTH - 1);
        push_word(MODE_LOAD, idx, rand_value(), 1'($urandom_range(1)));
    endtask

    task automatic random_row();
        int n;
        int r;
        int col;
        n = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(4, 1);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 8)
                random_load();
            else if (r < 11)
                push_word(MODE_IGNORED, $urandom, $urandom, 1'($urandom_range(1)));
            else if (r < 13)
                push_word(MODE_EMPTY, $urandom, $urandom, 1'($urandom_range(1)));
            if (cur_len == 0)
                col = $urandom_range(VECTOR_DEPTH - 1);
            else if (cur_len < VECTOR_DEPTH && $urandom_range(99) < 15)
                col = $urandom_range(VECTOR_DEPTH - 1, cur_len);
            else
                col = good_column();
            push_word(MODE_NONZERO, col, rand_value(), k == n - 1);
        end
    endtask

    task automatic random_phase(int len, int idling);
        int target;
        int r;
        wait_drain();
        write_length(len);
        set_idling(idling);
        repeat (8) push_word(MODE_LOAD, $urandom_range(column_limit() - 1), rand_value(), 1'b0);
        target = words_sent + WORDS_PER_PHASE;
        while (words_sent < target) begin
            r = $urandom_range(99);
            if (r < 75)
                random_row();
            else if (r < 85)
                push_word(MODE_EMPTY, $urandom, $urandom, 1'($urandom_range(1)));
            else if (r < 95)
                random_load();
            else
                push_word(MODE_IGNORED, $urandom, $urandom, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(0);

        // Short directed run at the reset length of 1024.
        push_word(MODE_LOAD, 0, 32'h0001_0000, 1'b1);
        push_word(MODE_LOAD, 1, 32'h8000_0000, 1'b0);
        push_word(MODE_LOAD, 2, 32'h7FFF_FFFF, 1'b0);
        push_word(MODE_LOAD, VECTOR_DEPTH - 1, 32'hFFFF_FFFF, 1'b0);
        push_word(MODE_NONZERO, 0, 32'h0002_8000, 1'b1);
        // Climb past the top bound, then keep accumulating from the clipped value.
        push_word(MODE_NONZERO, 1, 32'h8000_0000, 1'b0);
        push_word(MODE_NONZERO, 1, 32'h8000_0000, 1'b0);
        push_word(MODE_NONZERO, 2, 32'h8000_0000, 1'b1);
        // Fall past the bottom bound.
        push_word(MODE_NONZERO, 2, 32'h8000_0000, 1'b0);
        push_word(MODE_NONZERO, 2, 32'h8000_0000, 1'b0);
        push_word(MODE_NONZERO, 2, 32'h8000_0000, 1'b1);
        push_word(MODE_EMPTY, 0, 32'h0, 1'b0);
        // An empty row discards the partial row before it.
        push_word(MODE_NONZERO, VECTOR_DEPTH - 1, 32'h7FFF_FFFF, 1'b0);
        push_word(MODE_EMPTY, VECTOR_DEPTH - 1, 32'hFFFF_FFFF, 1'b1);
        push_word(MODE_IGNORED, VECTOR_DEPTH - 1, 32'hFFFF_FFFF, 1'b1);
        // A load in the middle of a row changes the entry for later nonzeros.
        push_word(MODE_NONZERO, 0, 32'hFFFF_FFFF, 1'b0);
        push_word(MODE_LOAD, 0, 32'h0003_0000, 1'b0);
        push_word(MODE_NONZERO, 0, 32'h0000_0001, 1'b1);

        wait_drain();
        write_length(2);
        push_word(MODE_NONZERO, 2, 32'h0000_0005, 1'b0);
        push_word(MODE_NONZERO, 1, 32'h0000_0001, 1'b1);
        push_word(MODE_NONZERO, VECTOR_DEPTH - 1, 32'h0001_0000, 1'b1);
        wait_drain();
        write_length(0);
        push_word(MODE_NONZERO, 0, 32'h0001_0000, 1'b1);
        wait_drain();
        write_length(2047);
        push_word(MODE_NONZERO, VECTOR_DEPTH - 1, 32'h0001_0000, 1'b1);

        random_phase(1024, 0);
        random_phase(1, 1);
        random_phase($urandom_range(63, 2), 2);
        random_phase(0, 3);
        random_phase(2047, 0);
        random_phase($urandom_range(1023, 64), 1);
        random_phase(1024, 2);
        random_phase($urandom_range(1023, 1), 3);

        wait_drain();
        if (sb.pending() != 0)
            sb.flag_mismatch($sformatf("%0d rows never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
